@@ design/byte_stream_line_statistics_unit_defines.svh @@
// assertion macros for the byte stream line statistics unit
`ifndef BYTE_STREAM_LINE_STATISTICS_UNIT_DEFINES_SVH
`define BYTE_STREAM_LINE_STATISTICS_UNIT_DEFINES_SVH

`ifndef SYNTH

// property checked while out of reset
`define BSLS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bsls assertion failed");

// property checked at every edge, reset included
`define BSLS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bsls assertion failed");

`else

`define BSLS_ASSERT(label, clk, rst, prop)
`define BSLS_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

@@ design/bsls_pkg.sv @@
package bsls_pkg;

  localparam int ALPHABET    = 256;
  localparam int CHUNK_BITS  = 8;
  localparam int CHUNKS      = ALPHABET / CHUNK_BITS;
  localparam int CHUNK_IDX_W = $clog2(CHUNKS);
  localparam int USED_BITS   = 9;
  localparam int FIELD_BITS  = 32;
  localparam int WIDE_BITS   = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;
  localparam logic       CMD_DATA     = 1'b0;
  localparam logic       CMD_FINISH   = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] line_count;
    logic [FIELD_BITS-1:0] char_count;
    logic [FIELD_BITS-1:0] shortest_line;
    logic [FIELD_BITS-1:0] longest_line;
    logic [USED_BITS-1:0]  alphabet_size;
  } rsp_t;

  typedef enum logic [1:0] {
    OP_CHAR,
    OP_LINE_END,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
  } entry_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_SWEEP,
    ST_REPORT
  } state_t;

  function automatic logic [3:0] popcount8(input logic [CHUNK_BITS-1:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < CHUNK_BITS; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

endpackage

@@ design/bsls_front.sv @@
`include "byte_stream_line_statistics_unit_defines.svh"

module bsls_front
  import bsls_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   req_valid,
  output logic   req_stall,
  input  req_t   req,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head
);

  entry_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   cnt;
  logic                push;
  entry_t              classified;

  // classify request
  always_comb begin
    classified.data_byte = req.data_byte;
    if (req.command == CMD_FINISH) begin
      classified.op = OP_FINISH;
    end else if (req.data_byte == NEWLINE_BYTE) begin
      classified.op = OP_LINE_END;
    end else begin
      classified.op = OP_CHAR;
    end
  end

  assign req_stall  = (cnt == QCNT_W'(QUEUE_DEPTH));
  assign push       = req_valid && !req_stall;
  assign head_valid = (cnt != '0);
  assign head       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  `BSLS_ASSERT(a_cnt_bound, clk, rst, cnt <= QCNT_W'(QUEUE_DEPTH))
  `BSLS_ASSERT(a_no_pop_empty, clk, rst, pop |-> head_valid)
  `BSLS_ASSERT(a_ptr_gap, clk, rst, (cnt == '0) |-> (wr_ptr == rd_ptr))

endmodule

@@ design/bsls_back.sv @@
`include "byte_stream_line_statistics_unit_defines.svh"

module bsls_back
  import bsls_pkg::*;
#(
  parameter int COUNT_BITS = 32
)
(
  input  logic   clk,
  input  logic   rst,
  input  logic   terminator_mode,
  input  logic   head_valid,
  input  entry_t head,
  output logic   pop,
  output logic   rsp_valid,
  input  logic   rsp_stall,
  output rsp_t   rsp
);

  state_t                 state;
  state_t                 state_next;
  logic [ALPHABET-1:0]    seen;
  logic [COUNT_BITS-1:0]  cur_len;
  logic [COUNT_BITS-1:0]  lines;
  logic [COUNT_BITS-1:0]  chars;
  logic [COUNT_BITS-1:0]  min_len;
  logic [COUNT_BITS-1:0]  max_len;
  logic [CHUNK_IDX_W-1:0] idx;
  logic [USED_BITS-1:0]   used;

  logic                   do_char;
  logic                   do_close;
  logic                   report;
  logic [COUNT_BITS-1:0]  len;
  logic [COUNT_BITS-1:0]  lines_inc;
  logic [COUNT_BITS-1:0]  chars_add;
  logic [COUNT_BITS:0]    chars_sum;
  logic [COUNT_BITS-1:0]  cur_inc;
  logic [CHUNK_BITS-1:0]  chunk;

  function automatic logic [FIELD_BITS-1:0] clamp_field(input logic [COUNT_BITS-1:0] v);
    logic [WIDE_BITS-1:0] w;
    w = WIDE_BITS'(v);
    return (w[WIDE_BITS-1:FIELD_BITS] != '0) ? '1 : w[FIELD_BITS-1:0];
  endfunction

  // saturating line close arithmetic
  always_comb begin
    len       = (terminator_mode && cur_len != '1) ? cur_len + 1'b1 : cur_len;
    lines_inc = (lines == '1) ? lines : lines + 1'b1;
    chars_sum = {1'b0, chars} + {1'b0, len};
    chars_add = chars_sum[COUNT_BITS] ? '1 : chars_sum[COUNT_BITS-1:0];
    cur_inc   = (cur_len == '1) ? cur_len : cur_len + 1'b1;
  end

  always_comb begin
    chunk = seen[int'(idx)*CHUNK_BITS +: CHUNK_BITS];
    if (idx == '0) begin
      chunk[0] = chunk[0] | (terminator_mode && lines != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    do_char    = 1'b0;
    do_close   = 1'b0;
    report     = 1'b0;
    unique case (state)
      ST_RUN: begin
        if (head_valid) begin
          pop = 1'b1;
          unique case (head.op)
            OP_CHAR:     do_char = 1'b1;
            OP_LINE_END: do_close = 1'b1;
            OP_FINISH: begin
              do_close   = (cur_len != '0);
              state_next = ST_SWEEP;
            end
            default: ;
          endcase
        end
      end
      ST_SWEEP: begin
        if (idx == CHUNK_IDX_W'(CHUNKS - 1)) begin
          state_next = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (!rsp_valid || !rsp_stall) begin
          report     = 1'b1;
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || report) begin
      seen    <= '0;
      cur_len <= '0;
      lines   <= '0;
      chars   <= '0;
      min_len <= '1;
      max_len <= '0;
    end else begin
      if (do_char) begin
        seen[head.data_byte] <= 1'b1;
        cur_len              <= cur_inc;
      end
      if (do_close) begin
        cur_len <= '0;
        lines   <= lines_inc;
        chars   <= chars_add;
        if (len < min_len) begin
          min_len <= len;
        end
        if (len > max_len) begin
          max_len <= len;
        end
      end
    end
  end

  // histogram walk, one chunk per cycle
  always_ff @(posedge clk) begin
    if (rst || state == ST_RUN) begin
      idx  <= '0;
      used <= '0;
    end else if (state == ST_SWEEP) begin
      idx  <= idx + 1'b1;
      used <= used + USED_BITS'(popcount8(chunk));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (report) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (report) begin
      rsp.line_count    <= clamp_field(lines);
      rsp.char_count    <= clamp_field(chars);
      rsp.shortest_line <= clamp_field(min_len);
      rsp.longest_line  <= clamp_field(max_len);
      rsp.alphabet_size <= used;
    end
  end

  `BSLS_ASSERT(a_pop_in_run, clk, rst, pop |-> (state == ST_RUN))
  `BSLS_ASSERT(a_min_le_max, clk, rst, (lines != '0) |-> (min_len <= max_len))
  `BSLS_ASSERT(a_report_clears, clk, rst, report |=> (lines == '0 && cur_len == '0 && rsp_valid))

endmodule

@@ design/byte_stream_line_statistics_unit.sv @@
// Byte stream line statistics. Each request carries a text byte or a finish command. Data
// bytes (newline ends a line) are taken at one per clock, while the 4-entry queue in
// front of the execution stage has room. A finish closes any pending line, then walks the
// 256-bit byte-seen map 8 values per cycle and, once the result register is free,
// registers the result on rsp; the queue keeps taking requests meanwhile until it fills.
// All counters saturate at COUNT_BITS ones and report clamped to 32 bits. The store
// clears itself after each report; terminator_mode (reset 1) is written over cfg only
// while the block is idle, a rule for the user that the block itself does not enforce.
module byte_stream_line_statistics_unit
  import bsls_pkg::*;
#(
  parameter int COUNT_BITS = 32
)
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);

  logic   terminator_mode;
  logic   head_valid;
  entry_t head;
  logic   pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      terminator_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      terminator_mode <= cfg_data;
    end
  end

  bsls_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  bsls_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .terminator_mode (terminator_mode),
    .head_valid      (head_valid),
    .head            (head),
    .pop             (pop),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .rsp             (rsp)
  );

endmodule

@@ test/tb_byte_stream_line_statistics_unit.sv @@
module tb_byte_stream_line_statistics_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bsls_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  byte_stream_line_statistics_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // statistics the block should be holding
  logic [31:0] byte_tally [ALPHABET];
  logic [31:0] line_total = '0;
  logic [31:0] char_total = '0;
  logic [31:0] min_line = '1;
  logic [31:0] max_line = '0;
  logic [31:0] open_len = '0;
  logic        term_mode = 1'b1;
  rsp_t        pending_reports [$];

  int mismatches = 0;
  int requests_sent = 0;
  int reports_checked = 0;
  int mode_writes = 0;
  int input_stall_cycles = 0;

  // sender and receiver idling
  int burst_left = 0;
  bit req_up = 0;
  int burst_max = 16;
  int gap_max = 6;
  int stall_pct = 15;
  int stall_left = 0;
  int hold_cycles = 0;

  initial forever #2 clk = ~clk;

  initial begin
    #2ms;
    $display("byte_stream_line_statistics_unit: mismatch");
    $finish;
  end

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

  function automatic void clear_statistics();
    for (int i = 0; i < ALPHABET; i++) begin
      byte_tally[i] = '0;
    end
    line_total = '0;
    char_total = '0;
    min_line = '1;
    max_line = '0;
    open_len = '0;
  endfunction

  function automatic void close_line();
    logic [31:0] len;
    len = term_mode ? sat_add(open_len, 1) : open_len;
    line_total = sat_add(line_total, 1);
    char_total = sat_add(char_total, len);
    if (len < min_line) min_line = len;
    if (len > max_line) max_line = len;
    open_len = '0;
  endfunction

  function automatic void tally_request(req_t item);
    rsp_t report;
    int used;
    if (item.command == CMD_DATA) begin
      if (item.data_byte == NEWLINE_BYTE) begin
        close_line();
      end else begin
        byte_tally[item.data_byte] = sat_add(byte_tally[item.data_byte], 1);
        open_len = sat_add(open_len, 1);
      end
    end else begin
      if (open_len != 0) close_line();
      used = 0;
      for (int i = 0; i < ALPHABET; i++) begin
        if (byte_tally[i] != 0 || (i == 0 && term_mode && line_total != 0)) used++;
      end
      report.line_count = line_total;
      report.char_count = char_total;
      report.shortest_line = min_line;
      report.longest_line = max_line;
      report.alphabet_size = USED_BITS'(used);
      pending_reports.push_back(report);
      clear_statistics();
    end
  endfunction

  function automatic void compare_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_report(rsp_t got);
    rsp_t want;
    if (pending_reports.size() == 0) begin
      $display("%0t: report with none expected, got %p", $time, got);
      mismatches++;
      return;
    end
    want = pending_reports.pop_front();
    reports_checked++;
    compare_field("line_count", want.line_count, got.line_count);
    compare_field("char_count", want.char_count, got.char_count);
    compare_field("shortest_line", want.shortest_line, got.shortest_line);
    compare_field("longest_line", want.longest_line, got.longest_line);
    compare_field("alphabet_size", 32'(want.alphabet_size), 32'(got.alphabet_size));
  endfunction

  // result side: check, then pick the next stall
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      check_report(rsp);
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      rsp_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else if ($urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(7);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  task automatic send_request(logic cmd, logic [7:0] value);
    req_t item;
    item.command = cmd;
    item.data_byte = value;
    if (burst_left <= 0) begin
      if (req_up) begin
        req_valid <= 1'b0;
        req_up = 0;
      end
      repeat ($urandom_range(gap_max, 1)) @(posedge clk);
      burst_left = $urandom_range(burst_max, 1);
    end
    req_valid <= 1'b1;
    req <= item;
    req_up = 1;
    do begin
      @(posedge clk);
      if (req_stall === 1'b1) input_stall_cycles++;
    end while (req_stall !== 1'b0);
    tally_request(item);
    requests_sent++;
    burst_left--;
  endtask

  task automatic drain_reports();
    if (req_up) begin
      req_valid <= 1'b0;
      req_up = 0;
    end
    burst_left = 0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (48) @(posedge clk);
  endtask

  task automatic write_terminator_mode(logic mode);
    drain_reports();
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    term_mode = mode;
    mode_writes++;
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = ($urandom_range(3) == 0) ? 8'($urandom_range(8'h7a, 8'h61)) : 8'($urandom_range(255));
    return (b == NEWLINE_BYTE) ? 8'h20 : b;
  endfunction

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      send_request(CMD_DATA, s[i]);
    end
  endtask

  // reset value of terminator mode, empty data set first
  task automatic test_reset_mode();
    send_request(CMD_FINISH, 8'h00);
    send_text("ab\n\n");
    send_request(CMD_FINISH, 8'h55);
  endtask

  task automatic test_byte_extremes();
    write_terminator_mode(1'b0);
    send_request(CMD_DATA, 8'h00);
    send_request(CMD_DATA, 8'hff);
    send_request(CMD_DATA, NEWLINE_BYTE);
    send_request(CMD_DATA, 8'hff);
    send_request(CMD_FINISH, 8'hff);
    send_request(CMD_FINISH, 8'h00);
  endtask

  task automatic test_empty_lines();
    send_text("\n\n");
    send_request(CMD_FINISH, NEWLINE_BYTE);
    write_terminator_mode(1'b1);
    send_text("\n");
    send_request(CMD_FINISH, 8'h80);
  endtask

  // pending line closed by finish, then an empty pending line
  task automatic test_pending_line();
    send_text("xyz");
    send_request(CMD_FINISH, 8'h01);
    send_text("q\n");
    send_request(CMD_FINISH, 8'h7f);
  endtask

  task automatic test_output_backpressure();
    drain_reports();
    burst_max = 1000;
    gap_max = 1;
    stall_pct = 0;
    hold_cycles = 400;
    repeat (8) begin
      repeat ($urandom_range(4)) send_request(CMD_DATA, text_byte());
      send_request(CMD_DATA, NEWLINE_BYTE);
      send_request(CMD_FINISH, 8'($urandom_range(255)));
    end
    drain_reports();
  endtask

  task automatic test_random_text(int count, logic mode, int bmax, int gmax, int spct,
                                  bit full_set);
    logic [7:0] pool [$];
    int stop_at;
    int choice;
    int len;
    int j;
    logic [7:0] t;
    write_terminator_mode(mode);
    burst_max = bmax;
    gap_max = gmax;
    stall_pct = spct;
    stop_at = requests_sent + count;
    if (full_set) begin
      // every byte value but newline in one data set
      for (int v = 0; v < ALPHABET; v++) begin
        if (v != NEWLINE_BYTE) pool.push_back(8'(v));
      end
      for (int i = pool.size() - 1; i > 0; i--) begin
        j = $urandom_range(i);
        t = pool[i];
        pool[i] = pool[j];
        pool[j] = t;
      end
      foreach (pool[i]) begin
        send_request(CMD_DATA, pool[i]);
        if ($urandom_range(15) == 0) send_request(CMD_DATA, NEWLINE_BYTE);
      end
      send_request(CMD_FINISH, 8'($urandom_range(255)));
    end
    while (requests_sent < stop_at) begin
      choice = $urandom_range(99);
      if (choice < 10) begin
        send_request($urandom_range(19) == 0, 8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(5)) begin
          len = ($urandom_range(9) == 0) ? $urandom_range(80) : $urandom_range(12);
          repeat (len) send_request(CMD_DATA, text_byte());
          send_request(CMD_DATA, NEWLINE_BYTE);
        end
        if ($urandom_range(1)) begin
          repeat ($urandom_range(8, 1)) send_request(CMD_DATA, text_byte());
        end
        send_request(CMD_FINISH, 8'($urandom_range(255)));
      end
    end
    send_request(CMD_FINISH, 8'($urandom_range(255)));
  endtask

  initial begin
    clear_statistics();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_mode();
    test_byte_extremes();
    test_empty_lines();
    test_pending_line();
    test_random_text(120, 1'b1, 16, 8, 20, 1'b0);
    test_random_text(0, 1'b0, 1000, 1, 0, 1'b1);
    test_output_backpressure();
    test_random_text(120, 1'b1, 4, 40, 50, 1'b0);
    test_random_text(120, 1'b0, 30, 12, 10, 1'b0);
    drain_reports();
    $display("%0d requests sent, %0d reports checked, terminator mode written %0d times",
             requests_sent, reports_checked, mode_writes);
    $display("input stalled for %0d cycles, including a 400-cycle hold on the result side",
             input_stall_cycles);
    if (mismatches == 0) begin
      $display("byte_stream_line_statistics_unit: match");
    end else begin
      $display("byte_stream_line_statistics_unit: mismatch");
    end
    $finish;
  end

endmodule
